>>> rtl/core/wit_pkg.sv
package wit_pkg;

  localparam int unsigned Lanes    = 4;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned PartW    = 17;
  localparam int unsigned CoefW    = 19;
  localparam int unsigned DimRegW  = 13;
  localparam int unsigned PadW     = 2;
  localparam int unsigned TileIdxW = 12;
  localparam int unsigned RowW     = 2;
  localparam int unsigned CmpW     = 18;
  localparam int unsigned KeptRows = 3;

  localparam logic [RowW-1:0] LastRow = 2'd3;

  typedef enum logic [1:0] {
    REG_IMAGE_HEIGHT = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_PAD_ROWS     = 2'd2,
    REG_PAD_COLS     = 2'd3
  } cfg_reg_e;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [PartW-1:0]   part_t;
  typedef logic signed [CoefW-1:0]   coef_t;

  typedef struct packed {
    logic [DimRegW-1:0] height;
    logic [DimRegW-1:0] width;
    logic [PadW-1:0]    pad_rows;
    logic [PadW-1:0]    pad_cols;
  } cfg_t;

  typedef struct packed {
    logic            wr;
    logic [RowW-1:0] row;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic draining;
  } obuf_stat_t;

endpackage

>>> rtl/core/winograd_input_tile_transform.sv
// latency: a tile's result row 0 is valid the cycle after its row 3 request is taken,
//   rows 1..3 follow one per cycle while out_ready_i stays high
// throughput: one input row per cycle if ready, four result rows per four input rows
// rows 0..2 are always taken; row 3 waits only while the single tile output buffer
//   still holds rows of the previous tile other than the one leaving this cycle
// reset: image size 4096 x 4096, no padding, output buffer empty; kept rows not cleared
module winograd_input_tile_transform #(
  parameter int unsigned MAX_IMAGE_DIM = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  wit_pkg::cfg_reg_e                 cfg_idx_i,
  input  logic [wit_pkg::DimRegW-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [wit_pkg::TileIdxW-1:0]      tile_col_i,
  input  logic [wit_pkg::TileIdxW-1:0]      tile_row_i,
  input  logic [wit_pkg::RowW-1:0]          row_in_tile_i,
  input  wit_pkg::sample_t                  sample_0_i,
  input  wit_pkg::sample_t                  sample_1_i,
  input  wit_pkg::sample_t                  sample_2_i,
  input  wit_pkg::sample_t                  sample_3_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [wit_pkg::RowW-1:0]          out_row_o,
  output wit_pkg::coef_t                    coef_0_o,
  output wit_pkg::coef_t                    coef_1_o,
  output wit_pkg::coef_t                    coef_2_o,
  output wit_pkg::coef_t                    coef_3_o,
  output logic                              tile_done_o
);
  import wit_pkg::*;

  cfg_t       cfg_q, cfg_d;
  sample_t    samples [Lanes];
  part_t      parts   [Lanes];
  coef_t      lane_coef [Lanes][Lanes];
  coef_t      tile    [Lanes][Lanes];
  coef_t      out_coef [Lanes];
  lane_ctrl_t lane_ctrl;
  obuf_stat_t obuf_stat;
  logic       is_last, in_fire, load;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_HEIGHT: cfg_d.height   = cfg_data_i;
        REG_IMAGE_WIDTH:  cfg_d.width    = cfg_data_i;
        REG_PAD_ROWS:     cfg_d.pad_rows = cfg_data_i[PadW-1:0];
        REG_PAD_COLS:     cfg_d.pad_cols = cfg_data_i[PadW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.height   <= DimRegW'(4096);
      cfg_q.width    <= DimRegW'(4096);
      cfg_q.pad_rows <= '0;
      cfg_q.pad_cols <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;

  assign is_last    = (row_in_tile_i == LastRow);
  assign in_ready_o = !is_last || !obuf_stat.busy || obuf_stat.draining;
  assign in_fire    = in_valid_i && in_ready_o;
  assign load       = in_fire && is_last;

  assign lane_ctrl.wr  = in_fire && !is_last;
  assign lane_ctrl.row = row_in_tile_i;

  wit_row_xform #(
    .MaxImageDim(MAX_IMAGE_DIM)
  ) u_row_xform (
    .cfg_i     (cfg_q),
    .tile_col_i(tile_col_i),
    .tile_row_i(tile_row_i),
    .row_i     (row_in_tile_i),
    .sample_i  (samples),
    .part_o    (parts)
  );

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    wit_col_lane u_lane (
      .clk_i (clk_i),
      .ctrl_i(lane_ctrl),
      .part_i(parts[k]),
      .coef_o(lane_coef[k])
    );
    for (genvar r = 0; r < Lanes; r++) begin : g_row
      assign tile[r][k] = lane_coef[k][r];
    end
  end

  wit_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .tile_i     (tile),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_row_o  (out_row_o),
    .coef_o     (out_coef),
    .tile_done_o(tile_done_o),
    .stat_o     (obuf_stat)
  );

  assign coef_0_o = out_coef[0];
  assign coef_1_o = out_coef[1];
  assign coef_2_o = out_coef[2];
  assign coef_3_o = out_coef[3];

`ifndef SYNTHESIS
  a_tile_starts_at_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o && (out_row_o == '0))
    else $error("tile load did not present result row 0");

  a_rows_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !tile_done_o
      |=> out_valid_o && (out_row_o == $past(out_row_o) + 2'd1))
    else $error("result rows did not advance by one");

  a_tile_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && tile_done_o |=> (out_valid_o == $past(load)))
    else $error("output valid after last row does not match a new tile load");

  a_early_rows_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !is_last |-> in_ready_o)
    else $error("tile rows 0..2 stalled");
`endif

endmodule

>>> rtl/core/wit_row_xform.sv
module wit_row_xform #(
  parameter int unsigned MaxImageDim = 4096
) (
  input  wit_pkg::cfg_t                        cfg_i,
  input  logic [wit_pkg::TileIdxW-1:0]         tile_col_i,
  input  logic [wit_pkg::TileIdxW-1:0]         tile_row_i,
  input  logic [wit_pkg::RowW-1:0]             row_i,
  input  wit_pkg::sample_t                     sample_i [wit_pkg::Lanes],
  output wit_pkg::part_t                       part_o   [wit_pkg::Lanes]
);
  import wit_pkg::*;

  localparam logic [CmpW-1:0] MaxDim = CmpW'(MaxImageDim);

  logic [CmpW-1:0] h_eff, w_eff;
  logic [CmpW-1:0] y_pos, y_lim, x_lim, pad_r, pad_c;
  logic [CmpW-1:0] x_pos [Lanes];
  logic            y_in;
  sample_t         d [Lanes];

  always_comb begin
    h_eff = (CmpW'(cfg_i.height) > MaxDim) ? MaxDim : CmpW'(cfg_i.height);
    w_eff = (CmpW'(cfg_i.width) > MaxDim) ? MaxDim : CmpW'(cfg_i.width);
    pad_r = CmpW'(cfg_i.pad_rows);
    pad_c = CmpW'(cfg_i.pad_cols);
    // positions kept offset by the padding so everything stays unsigned
    y_pos = CmpW'({tile_row_i, 1'b0}) + CmpW'(row_i);
    y_lim = h_eff + pad_r;
    x_lim = w_eff + pad_c;
    y_in  = (y_pos >= pad_r) && (y_pos < y_lim);
    for (int k = 0; k < Lanes; k++) begin
      x_pos[k] = CmpW'({tile_col_i, 1'b0}) + CmpW'(k);
      d[k] = (y_in && (x_pos[k] >= pad_c) && (x_pos[k] < x_lim)) ? sample_i[k] : '0;
    end
    part_o[0] = PartW'(d[0]) - PartW'(d[2]);
    part_o[1] = PartW'(d[1]) + PartW'(d[2]);
    part_o[2] = PartW'(d[2]) - PartW'(d[1]);
    part_o[3] = PartW'(d[1]) - PartW'(d[3]);
  end

endmodule

>>> rtl/core/wit_col_lane.sv
module wit_col_lane (
  input  logic                clk_i,
  input  wit_pkg::lane_ctrl_t ctrl_i,
  input  wit_pkg::part_t      part_i,
  output wit_pkg::coef_t      coef_o [wit_pkg::Lanes]
);
  import wit_pkg::*;

  // row-transformed rows 0..2 of this column
  part_t slot_q [KeptRows];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KeptRows; i++) begin
      if (ctrl_i.wr && (ctrl_i.row == RowW'(i))) begin
        slot_q[i] <= part_i;
      end
    end
  end

  // down-the-column butterfly, row 3 taken straight from the input
  always_comb begin
    coef_o[0] = CoefW'(slot_q[0]) - CoefW'(slot_q[2]);
    coef_o[1] = CoefW'(slot_q[1]) + CoefW'(slot_q[2]);
    coef_o[2] = CoefW'(slot_q[2]) - CoefW'(slot_q[1]);
    coef_o[3] = CoefW'(slot_q[1]) - CoefW'(part_i);
  end

endmodule

>>> rtl/core/wit_out_buf.sv
module wit_out_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  wit_pkg::coef_t              tile_i [wit_pkg::Lanes][wit_pkg::Lanes],
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [wit_pkg::RowW-1:0]    out_row_o,
  output wit_pkg::coef_t              coef_o [wit_pkg::Lanes],
  output logic                        tile_done_o,
  output wit_pkg::obuf_stat_t         stat_o
);
  import wit_pkg::*;

  logic            busy_q, busy_d;
  logic [RowW-1:0] row_q, row_d;
  coef_t           tile_q [Lanes][Lanes];
  logic            fire, last;

  assign fire = busy_q && out_ready_i;
  assign last = (row_q == LastRow);

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    if (fire) begin
      row_d = row_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (load_i) begin
      busy_d = 1'b1;
      row_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tile_q <= tile_i;
    end
  end

  assign out_valid_o     = busy_q;
  assign out_row_o       = row_q;
  assign coef_o          = tile_q[row_q];
  assign tile_done_o     = last;
  assign stat_o.busy     = busy_q;
  assign stat_o.draining = fire && last;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wit_pkg::*;

  localparam int unsigned MaxImageDim = 4096;
  localparam int WatchdogLimit = 2000;
  localparam int SinkHoldCycles = 300;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [RowW-1:0]             row;
    logic [Lanes-1:0][CoefW-1:0] coef;
    logic                        done;
  } coef_row_t;

  // predicts the transformed rows of each tile and checks them in order
  class winograd_tile_predictor;
    logic [DimRegW-1:0] height;
    logic [DimRegW-1:0] width;
    logic [PadW-1:0]    pad_r;
    logic [PadW-1:0]    pad_c;
    part_t              kept [KeptRows][Lanes];
    coef_row_t          rows_due [$];
    int                 errors;

    function new();
      height = 13'd4096;
      width  = 13'd4096;
      pad_r  = '0;
      pad_c  = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [DimRegW-1:0] val);
      case (idx)
        REG_IMAGE_HEIGHT: height = val;
        REG_IMAGE_WIDTH:  width  = val;
        REG_PAD_ROWS:     pad_r  = val[PadW-1:0];
        REG_PAD_COLS:     pad_c  = val[PadW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    function void take_row(logic [TileIdxW-1:0] tcol, logic [TileIdxW-1:0] trow,
                           logic [RowW-1:0] r, logic [Lanes-1:0][SampleW-1:0] s);
      int h, w, x0, y, a, b, c, e;
      int d [Lanes];
      int t [Lanes];
      int v [4][Lanes];
      coef_row_t res;
      h  = (height > MaxImageDim) ? MaxImageDim : int'(height);
      w  = (width > MaxImageDim) ? MaxImageDim : int'(width);
      x0 = 2 * int'(tcol) - int'(pad_c);
      y  = 2 * int'(trow) - int'(pad_r) + int'(r);
      for (int k = 0; k < Lanes; k++) begin
        if (x0 + k >= 0 && x0 + k < w && y >= 0 && y < h) d[k] = $signed(s[k]);
        else d[k] = 0;
      end
      t[0] = d[0] - d[2];
      t[1] = d[1] + d[2];
      t[2] = d[2] - d[1];
      t[3] = d[1] - d[3];
      if (r != LastRow) begin
        for (int k = 0; k < Lanes; k++) kept[r][k] = part_t'(t[k]);
        return;
      end
      for (int k = 0; k < Lanes; k++) begin
        a = kept[0][k];
        b = kept[1][k];
        c = kept[2][k];
        e = t[k];
        v[0][k] = a - c;
        v[1][k] = b + c;
        v[2][k] = c - b;
        v[3][k] = b - e;
      end
      for (int i = 0; i < 4; i++) begin
        res.row  = RowW'(i);
        res.done = (i == 3);
        for (int k = 0; k < Lanes; k++) res.coef[k] = coef_t'(v[i][k]);
        rows_due.push_back(res);
      end
    endfunction

    function void check_coef_row(logic [RowW-1:0] row, logic [Lanes-1:0][CoefW-1:0] coef,
                                 logic done);
      coef_row_t want;
      if (rows_due.size() == 0) begin
        $display("%0t: result row %0d with no tile pending", $time, row);
        errors++;
        return;
      end
      want = rows_due.pop_front();
      if (want.row !== row) begin
        $display("%0t: out_row expected %0d got %0d", $time, want.row, row);
        errors++;
      end
      for (int k = 0; k < Lanes; k++) begin
        if (want.coef[k] !== coef[k]) begin
          $display("%0t: coef_%0d of row %0d expected %0d got %0d", $time, k, want.row,
                   $signed(want.coef[k]), $signed(coef[k]));
          errors++;
        end
      end
      if (want.done !== done) begin
        $display("%0t: tile_done expected %0b got %0b", $time, want.done, done);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_reg_e              cfg_idx = REG_IMAGE_HEIGHT;
  logic [DimRegW-1:0]    cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TileIdxW-1:0]   tile_col = '0;
  logic [TileIdxW-1:0]   tile_row = '0;
  logic [RowW-1:0]       row_in_tile = '0;
  sample_t               sample_0 = '0;
  sample_t               sample_1 = '0;
  sample_t               sample_2 = '0;
  sample_t               sample_3 = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RowW-1:0]       out_row;
  coef_t                 coef_0;
  coef_t                 coef_1;
  coef_t                 coef_2;
  coef_t                 coef_3;
  logic                  tile_done;

  winograd_tile_predictor sb = new();
  int  rows_sent = 0;
  bit  sink_hold = 1'b0;
  bit  src_steady = 1'b0;
  bit  sink_steady = 1'b0;
  logic [KeptRows-1:0] kept_mask = '0;

  winograd_input_tile_transform #(
    .MAX_IMAGE_DIM(MaxImageDim)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .tile_col_i   (tile_col),
    .tile_row_i   (tile_row),
    .row_in_tile_i(row_in_tile),
    .sample_0_i   (sample_0),
    .sample_1_i   (sample_1),
    .sample_2_i   (sample_2),
    .sample_3_i   (sample_3),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_row_o    (out_row),
    .coef_0_o     (coef_0),
    .coef_1_o     (coef_1),
    .coef_2_o     (coef_2),
    .coef_3_o     (coef_3),
    .tile_done_o  (tile_done)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      default: return SampleW'($urandom());
    endcase
  endfunction

  function automatic logic [Lanes-1:0][SampleW-1:0] rand_samples();
    logic [Lanes-1:0][SampleW-1:0] s;
    for (int k = 0; k < Lanes; k++) s[k] = rand_sample();
    return s;
  endfunction

  // mostly tiles that touch the image, so its borders and the padding get hit
  function automatic logic [TileIdxW-1:0] pick_idx(logic [DimRegW-1:0] dim,
                                                   logic [PadW-1:0] pad);
    int span;
    span = ((dim > MaxImageDim ? MaxImageDim : int'(dim)) + int'(pad)) / 2 + 1;
    if ($urandom_range(0, 3) == 0) return TileIdxW'($urandom_range(0, 4095));
    return TileIdxW'($urandom_range(0, span > 4095 ? 4095 : span));
  endfunction

  function automatic int draw_gap(ref bit steady);
    if ($urandom_range(0, 11) == 0) steady = ~steady;
    return steady ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_row(input logic [TileIdxW-1:0] tcol, input logic [TileIdxW-1:0] trow,
                          input logic [RowW-1:0] r, input logic [Lanes-1:0][SampleW-1:0] s);
    int gap;
    gap = draw_gap(src_steady);
    // never let the last row arrive over kept rows that were never written
    if (r == LastRow && kept_mask != '1) begin
      for (int i = KeptRows - 1; i >= 0; i--) if (!kept_mask[i]) r = RowW'(i);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    tile_col    <= tcol;
    tile_row    <= trow;
    row_in_tile <= r;
    sample_0    <= s[0];
    sample_1    <= s[1];
    sample_2    <= s[2];
    sample_3    <= s[3];
    do @(posedge clk_i); while (!in_ready);
    sb.take_row(tcol, trow, r, s);
    if (r != LastRow) kept_mask[r] = 1'b1;
    rows_sent++;
  endtask

  task automatic send_tile(input logic [TileIdxW-1:0] tcol, input logic [TileIdxW-1:0] trow);
    for (int r = 0; r < 4; r++) send_row(tcol, trow, RowW'(r), rand_samples());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DimRegW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input logic [DimRegW-1:0] h, input logic [DimRegW-1:0] w,
                           input logic [PadW-1:0] pr, input logic [PadW-1:0] pc);
    wait_drained();
    // rows 0..2 give no result, so let the pipe settle before touching the registers
    repeat (DrainCycles) @(posedge clk_i);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_PAD_ROWS, DimRegW'(pr));
    write_reg(REG_PAD_COLS, DimRegW'(pc));
    cfg_we <= 1'b0;
  endtask

  // result side
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold) begin
        gap = SinkHoldCycles;
        sink_hold = 1'b0;
      end else begin
        gap = draw_gap(sink_steady);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      sb.check_coef_row(out_row, {coef_3, coef_2, coef_1, coef_0}, tile_done);
    end
  end

  // no handshake for too long means the block hung
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no request or result moved for %0d cycles", $time, WatchdogLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int target;
    bit paused;
    logic [DimRegW-1:0] h, w;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed tiles under the reset setting
    for (int r = 0; r < 4; r++) send_row(0, 0, RowW'(r), {4{16'h7fff}});
    for (int r = 0; r < 4; r++) send_row(0, 0, RowW'(r), {4{16'h8000}});
    // rows 0 and 2 at opposite extremes drive the largest positive coefficient
    send_row(1, 1, 0, {16'h8000, 16'h8000, 16'h8000, 16'h7fff});
    send_row(1, 1, 1, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    send_row(1, 1, 2, {16'h7fff, 16'h7fff, 16'h7fff, 16'h8000});
    send_row(1, 1, 3, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    // out of order rows, then a repeated row with the last row reusing kept rows
    send_row(3, 2, 2, rand_samples());
    send_row(3, 2, 0, rand_samples());
    send_row(3, 2, 1, rand_samples());
    send_row(3, 2, 3, rand_samples());
    send_row(5, 7, 0, rand_samples());
    send_row(5, 7, 0, rand_samples());
    send_row(5, 7, 3, rand_samples());
    // far corner lies outside the image
    send_tile(12'hfff, 12'hfff);

    paused = 1'b0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_cfg(13'd1, 13'd1, 2'd3, 2'd3);
        1: apply_cfg(13'd4096, 13'd4096, 2'd0, 2'd0);
        2: apply_cfg(13'd8191, 13'd0, 2'd1, 2'd2);
        3: apply_cfg(13'd5, 13'd6, 2'd1, 2'd1);
        4: begin
          h = DimRegW'($urandom_range(1, 64));
          w = DimRegW'($urandom_range(1, 64));
          apply_cfg(h, w, PadW'($urandom_range(0, 3)), PadW'($urandom_range(0, 3)));
        end
        default: apply_cfg(13'd4095, 13'd4097, 2'd2, 2'd0);
      endcase
      if (phase == 3) sink_hold = 1'b1;
      target = rows_sent + 40;
      while (rows_sent < target) begin
        if (phase == 4 && !paused && rows_sent >= target - 20) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 4) != 0) begin
          send_tile(pick_idx(sb.width, sb.pad_c), pick_idx(sb.height, sb.pad_r));
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_row(pick_idx(sb.width, sb.pad_c), pick_idx(sb.height, sb.pad_r),
                     RowW'($urandom_range(0, 3)), rand_samples());
          end
        end
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
